@@ rtl/aes_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AES package
// Payload types, controller/datapath command struct, S-box tables
// and GF(2^8) helpers shared by the cipher modules.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam logic [7:0] POLY_LOW = 8'h1b;
  localparam logic [7:0] TOP_BIT  = 8'h80;
  localparam int unsigned CFG_IDX_W = 2;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_first_half;
    logic [63:0] block_second_half;
    logic        final_block;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_first_half;
    logic [63:0] result_second_half;
    logic        result_final;
  } aes_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_block;   // capture input block (also reused for the initial key add)
    logic round_step;   // apply one cipher round
    logic last_round;   // round without (inv) MixColumns
    logic key_init;     // load key words into schedule window
    logic key_step;     // produce one expanded key word
  } aes_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ ((a & TOP_BIT) != 8'h00 ? POLY_LOW : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = a;
    for (int k = 0; k < 4; k++) begin
      if (b[k]) acc = acc ^ p;
      p = xtime(p);
    end
    gmul = acc;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage : aes_pkg
`default_nettype wire

@@ rtl/aes_key_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AES round-key store
// Holds the expanded key words, one word written and one round (four words)
// read per cycle, read data registered.
// ----------------------------------------------------------------------------
module aes_key_ram
  import aes_pkg::*;
#(
  parameter int unsigned ROUNDS = 14
) (
  input  wire  logic                             clk,
  input  wire  logic                             wr_en,
  input  wire  logic [$clog2(4*(ROUNDS+1))-1:0]  wr_addr,
  input  wire  logic [31:0]                      wr_data,
  input  wire  logic [$clog2(ROUNDS+1)-1:0]      rd_round,
  output logic [127:0]                           rd_data
);

  localparam int unsigned DEPTH = ROUNDS + 1;

  // one row per round, four words per row; word lane selected on write
  logic [31:0] mem0 [DEPTH];
  logic [31:0] mem1 [DEPTH];
  logic [31:0] mem2 [DEPTH];
  logic [31:0] mem3 [DEPTH];
  logic [$clog2(ROUNDS+1)-1:0] wr_row;

  assign wr_row = wr_addr[$clog2(4*(ROUNDS+1))-1:2];

  // write one word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_addr[1:0])
        2'd0: mem0[wr_row] <= wr_data;
        2'd1: mem1[wr_row] <= wr_data;
        2'd2: mem2[wr_row] <= wr_data;
        default: mem3[wr_row] <= wr_data;
      endcase
    end
  end

  // read one round key
  always_ff @(posedge clk) begin
    rd_data <= {mem0[rd_round], mem1[rd_round], mem2[rd_round], mem3[rd_round]};
  end

endmodule : aes_key_ram
`default_nettype wire

@@ rtl/aes_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AES datapath
// State register with one encrypt or decrypt round per cycle, and the key
// schedule window that produces one expanded word per cycle.
// ----------------------------------------------------------------------------
module aes_datapath
  import aes_pkg::*;
#(
  parameter int unsigned KEY_WORDS = 8
) (
  input  wire  logic          clk,
  input  wire  aes_cmd_t      cmd,
  input  wire  aes_in_t       in_item,
  input  wire  logic [255:0]  key,
  input  wire  logic [127:0]  round_key,
  input  wire  logic          kw_sub_rot,   // word index is multiple of KEY_WORDS
  input  wire  logic          kw_sub_only,  // word index is 4 mod KEY_WORDS, long keys
  output logic [31:0]         key_word,     // word produced by this step
  output logic [127:0]        state_q,
  output logic                mode_q,
  output logic                final_q
);

  logic [31:0]  win_r [KEY_WORDS];
  logic [31:0]  win_nxt [KEY_WORDS];
  logic [7:0]   rcon_r, rcon_nxt;
  logic [127:0] state_r, state_nxt;
  logic         mode_r, final_r;
  logic [127:0] fwd_v, inv_v;
  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [7:0]   k [16];
  logic [31:0]  tw;

  // next key word from the schedule window
  always_comb begin
    tw = win_r[KEY_WORDS-1];
    if (kw_sub_rot) begin
      tw = sub_word({tw[23:0], tw[31:24]}) ^ {rcon_r, 24'h0};
    end else if (kw_sub_only) begin
      tw = sub_word(tw);
    end
    key_word = win_r[0] ^ tw;
  end

  // shift the window, or load it from the key
  always_comb begin
    rcon_nxt = rcon_r;
    for (int i = 0; i < KEY_WORDS; i++) win_nxt[i] = win_r[i];
    if (cmd.key_init) begin
      rcon_nxt = 8'h01;
      for (int i = 0; i < KEY_WORDS; i++) win_nxt[i] = key[255-32*i -: 32];
    end else if (cmd.key_step) begin
      for (int i = 0; i < KEY_WORDS-1; i++) win_nxt[i] = win_r[i+1];
      win_nxt[KEY_WORDS-1] = key_word;
      if (kw_sub_rot) rcon_nxt = xtime(rcon_r);
    end
  end

  // one round; byte b sits at state[127-8b -: 8]
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      s[b] = state_r[127-8*b -: 8];
      k[b] = round_key[127-8*b -: 8];
    end
    // encrypt: SubBytes, ShiftRows, MixColumns, AddRoundKey
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        m[4*c+r] = gmul(t[4*c+r], 4'd2) ^ gmul(t[4*c+(r+1)%4], 4'd3)
                 ^ t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4];
    for (int b = 0; b < 16; b++)
      fwd_v[127-8*b -: 8] = (cmd.last_round ? t[b] : m[b]) ^ k[b];
    // decrypt: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = INV_SBOX[s[4*((c+4-r)%4)+r]] ^ k[4*c+r];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        m[4*c+r] = gmul(t[4*c+r], 4'd14) ^ gmul(t[4*c+(r+1)%4], 4'd11)
                 ^ gmul(t[4*c+(r+2)%4], 4'd13) ^ gmul(t[4*c+(r+3)%4], 4'd9);
    for (int b = 0; b < 16; b++)
      inv_v[127-8*b -: 8] = cmd.last_round ? t[b] : m[b];
  end

  // select state update
  always_comb begin
    state_nxt = state_r;
    if (cmd.load_block) begin
      state_nxt = {in_item.block_first_half, in_item.block_second_half};
    end else if (cmd.round_step) begin
      state_nxt = mode_r ? inv_v : fwd_v;
    end else if (cmd.last_round) begin
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    rcon_r  <= rcon_nxt;
    state_r <= state_nxt;
    for (int i = 0; i < KEY_WORDS; i++) win_r[i] <= win_nxt[i];
    if (cmd.load_block) begin
      mode_r  <= in_item.mode;
      final_r <= in_item.final_block;
    end
  end

  assign state_q = state_r;
  assign mode_q  = mode_r;
  assign final_q = final_r;

endmodule : aes_datapath
`default_nettype wire

@@ rtl/aes_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion, the initial key addition, the rounds and the
// output register handshake.
// ----------------------------------------------------------------------------
module aes_ctrl
  import aes_pkg::*;
#(
  parameter int unsigned ROUNDS    = 14,
  parameter int unsigned KEY_WORDS = 8
) (
  input  wire  logic                             clk,
  input  wire  logic                             rst_n,
  input  wire  logic                             in_valid,
  output logic                                   in_stall,
  input  wire  logic                             in_mode,
  input  wire  logic                             key_dirty,
  output logic                                   key_done,
  input  wire  logic                             mode_q,
  output aes_cmd_t                               cmd,
  output logic                                   kw_sub_rot,
  output logic                                   kw_sub_only,
  output logic                                   wr_en,
  output logic [$clog2(4*(ROUNDS+1))-1:0]        wr_addr,
  output logic [$clog2(ROUNDS+1)-1:0]            rd_round,
  output logic                                   add_first,
  output logic                                   out_load,
  input  wire  logic                             out_busy
);

  localparam int unsigned WORDS = 4 * (ROUNDS + 1);
  localparam int unsigned WA_W  = $clog2(WORDS);
  localparam int unsigned RD_W  = $clog2(ROUNDS + 1);
  localparam int unsigned KM_W  = $clog2(KEY_WORDS);

  typedef enum logic [2:0] {
    S_IDLE, S_KEYLOAD, S_KEYGEN, S_FETCH, S_ADD0, S_ROUND, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [WA_W-1:0] widx_r, widx_nxt;    // next word index to write
  logic [KM_W:0]   kmod_r, kmod_nxt;    // widx mod KEY_WORDS
  logic [RD_W-1:0] rnd_r, rnd_nxt;      // current round number

  assign kw_sub_rot  = (kmod_r == '0);
  assign kw_sub_only = (KEY_WORDS > 6) && (kmod_r == (KM_W+1)'(4));

  always_comb begin
    state_nxt = state_r;
    widx_nxt  = widx_r;
    kmod_nxt  = kmod_r;
    rnd_nxt   = rnd_r;
    cmd       = '0;
    wr_en     = 1'b0;
    wr_addr   = widx_r;
    key_done  = 1'b0;
    add_first = 1'b0;
    out_load  = 1'b0;
    in_stall  = 1'b1;
    rd_round  = rnd_r;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_block = 1'b1;
          if (key_dirty) begin
            state_nxt = S_KEYLOAD;
          end else begin
            state_nxt = S_FETCH;
          end
          rd_round = in_mode ? RD_W'(ROUNDS) : '0;
        end
      end
      // copy key into window
      S_KEYLOAD: begin
        cmd.key_init = 1'b1;
        widx_nxt     = '0;
        state_nxt    = S_KEYGEN;
      end
      S_KEYGEN: begin
        // first KEY_WORDS words are the key itself, window head
        wr_en = 1'b1;
        if (widx_r < WA_W'(KEY_WORDS)) begin
          wr_addr = widx_r;
        end
        cmd.key_step = (widx_r >= WA_W'(KEY_WORDS));
        if (widx_r == WA_W'(KEY_WORDS - 1)) kmod_nxt = '0;
        else if (widx_r >= WA_W'(KEY_WORDS))
          kmod_nxt = (kmod_r == (KM_W+1)'(KEY_WORDS-1)) ? '0 : kmod_r + 1'b1;
        widx_nxt = widx_r + 1'b1;
        if (widx_r == WA_W'(WORDS - 1)) begin
          key_done  = 1'b1;
          state_nxt = S_FETCH;
        end
        rd_round = mode_q ? RD_W'(ROUNDS) : '0;
      end
      // read data for the first round key becomes valid
      S_FETCH: begin
        rd_round  = mode_q ? RD_W'(ROUNDS) : '0;
        state_nxt = S_ADD0;
        rnd_nxt   = '0;
      end
      S_ADD0: begin
        add_first = 1'b1;
        rd_round  = mode_q ? RD_W'(ROUNDS - 1) : RD_W'(1);
        state_nxt = S_ROUND;
        rnd_nxt   = RD_W'(1);
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        cmd.last_round = (rnd_r == RD_W'(ROUNDS));
        rd_round = mode_q ? RD_W'(ROUNDS) - rnd_r - 1'b1 : rnd_r + 1'b1;
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == RD_W'(ROUNDS)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      widx_r  <= '0;
      kmod_r  <= '0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      widx_r  <= widx_nxt;
      kmod_r  <= kmod_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

endmodule : aes_ctrl
`default_nettype wire

@@ rtl/aes_block_cipher.sv @@
`default_nettype none
// Sequence: from accept to result valid a block passes key fetch, initial key add,
//   ROUND_COUNT rounds and output load; key expansion comes first on the first
//   block after reset or any key write.
// One round unit: a new block is accepted only after the last result is loaded out.
// Reset: synchronous active-low rst_n clears control and the key registers and
//   marks the key schedule stale; the round-key store itself is not cleared.
// ----------------------------------------------------------------------------
// AES block cipher top level
// ECB encrypt/decrypt of one 128-bit block with a configurable key.
// ----------------------------------------------------------------------------
module aes_block_cipher
  import aes_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 14,
  parameter int unsigned KEY_WORDS   = 8
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  in_valid,
  output logic                        in_stall,
  input  wire  aes_in_t               in_data,
  output logic                        out_valid,
  input  wire  logic                  out_stall,
  output aes_out_t                    out_data,
  input  wire  logic                  cfg_valid,
  output logic                        cfg_ready,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [63:0]           cfg_value
);

  localparam int unsigned WA_W = $clog2(4 * (ROUND_COUNT + 1));
  localparam int unsigned RD_W = $clog2(ROUND_COUNT + 1);

  logic [63:0]     key_r [4];
  logic            dirty_r;
  logic            key_done;
  aes_cmd_t        cmd, dp_cmd;
  logic            kw_sub_rot, kw_sub_only;
  logic            wr_en;
  logic [WA_W-1:0] wr_addr;
  logic [RD_W-1:0] rd_round;
  logic [127:0]    rk, state_q;
  logic [31:0]     key_word, wr_data;
  logic            mode_q, final_q;
  logic            add_first, out_load;
  logic            out_valid_r;
  aes_out_t        out_r;
  logic [255:0]    key_flat;
  aes_in_t         dp_in;

  assign cfg_ready = 1'b1;
  assign key_flat  = {key_r[0], key_r[1], key_r[2], key_r[3]};

  // hold key registers; mark schedule stale on any write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      dirty_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        key_r[cfg_index] <= cfg_value;
        dirty_r <= 1'b1;
      end else if (key_done) begin
        dirty_r <= 1'b0;
      end
    end
  end

  aes_ctrl #(.ROUNDS(ROUND_COUNT), .KEY_WORDS(KEY_WORDS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_mode(in_data.mode), .key_dirty(dirty_r), .key_done, .mode_q,
    .cmd, .kw_sub_rot, .kw_sub_only, .wr_en, .wr_addr, .rd_round,
    .add_first, .out_load, .out_busy(out_valid_r && out_stall)
  );

  // key words below KEY_WORDS come straight from the key
  always_comb begin
    wr_data = key_word;
    for (int i = 0; i < KEY_WORDS; i++)
      if (wr_addr == WA_W'(i)) wr_data = key_flat[255-32*i -: 32];
  end

  aes_key_ram #(.ROUNDS(ROUND_COUNT)) u_ram (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_round, .rd_data(rk)
  );

  // initial key add reuses the load path with the state pre-xored
  always_comb begin
    dp_cmd = cmd;
    dp_in  = in_data;
    if (add_first) begin
      dp_cmd.load_block = 1'b1;
      dp_in.block_first_half  = state_q[127:64] ^ rk[127:64];
      dp_in.block_second_half = state_q[63:0] ^ rk[63:0];
      dp_in.mode        = mode_q;
      dp_in.final_block = final_q;
    end
  end

  aes_datapath #(.KEY_WORDS(KEY_WORDS)) u_dp (
    .clk, .cmd(dp_cmd), .in_item(dp_in), .key(key_flat), .round_key(rk),
    .kw_sub_rot, .kw_sub_only, .key_word, .state_q, .mode_q, .final_q
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.result_first_half  <= state_q[127:64];
      out_r.result_second_half <= state_q[63:0];
      out_r.result_final       <= final_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : aes_block_cipher
`default_nettype wire
